/* rtl/fsc_pkg.sv */
package fsc_pkg;

  localparam int unsigned CntW   = 6;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned LenW   = 7;
  localparam int unsigned FqcW   = 7;
  localparam int unsigned QueueW = 6;

  localparam logic [15:0] EthArp  = 16'h0806;
  localparam logic [15:0] EthVlan = 16'h8100;
  localparam logic [15:0] EthIpv6 = 16'h86DD;
  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  ProtoIcmpv6 = 8'd58;

  localparam logic [2:0] CfgSrcCount = 3'd0;
  localparam logic [2:0] CfgDstCount = 3'd1;
  localparam logic [2:0] CfgFlowEt   = 3'd2;
  localparam logic [2:0] CfgFqc      = 3'd3;
  localparam logic [2:0] CfgSockMask = 3'd4;

  localparam logic [2:0] RsnRedirect  = 3'd0;
  localparam logic [2:0] RsnMalformed = 3'd1;
  localparam logic [2:0] RsnArp       = 3'd2;
  localparam logic [2:0] RsnIcmp      = 3'd3;
  localparam logic [2:0] RsnNoSocket  = 3'd4;
  localparam logic [2:0] RsnFiltered  = 3'd5;

  typedef enum logic [1:0] {
    StIdle,
    StStart,
    StRun
  } state_e;

  // token handed from cell to cell along the rule chain
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] src_addr;
    logic [AddrW-1:0] dst_addr;
    logic             src_hit;
    logic             dst_hit;
  } link_t;

  typedef struct packed {
    logic             en;
    logic             table_sel;
    logic [4:0]       index;
    logic [AddrW-1:0] network;
    logic [AddrW-1:0] mask;
  } rule_wr_t;

endpackage

/* rtl/fsc_cell.sv */
module fsc_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fsc_pkg::rule_wr_t        wr_i,
  input  logic [fsc_pkg::CntW-1:0] src_nrules_i,
  input  logic [fsc_pkg::CntW-1:0] dst_nrules_i,
  input  fsc_pkg::link_t           link_i,
  output fsc_pkg::link_t           link_o
);
  import fsc_pkg::*;

  logic [AddrW-1:0] src_net_q, src_mask_q, dst_net_q, dst_mask_q;
  logic             valid_q;
  logic [AddrW-1:0] src_addr_q, dst_addr_q;
  logic             src_hit_q, dst_hit_q;
  logic             hit_src, hit_dst, wr_here;

  assign wr_here = wr_i.en && (32'(wr_i.index) == 32'(Idx));

  always_ff @(posedge clk_i) begin
    if (wr_here && !wr_i.table_sel) begin
      src_net_q  <= wr_i.network;
      src_mask_q <= wr_i.mask;
    end
    if (wr_here && wr_i.table_sel) begin
      dst_net_q  <= wr_i.network;
      dst_mask_q <= wr_i.mask;
    end
  end

  // a cell only counts when it lies below the programmed rule count
  assign hit_src = (32'(Idx) < 32'(src_nrules_i)) &&
                   ((link_i.src_addr & src_mask_q) == (src_net_q & src_mask_q));
  assign hit_dst = (32'(Idx) < 32'(dst_nrules_i)) &&
                   ((link_i.dst_addr & dst_mask_q) == (dst_net_q & dst_mask_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    src_addr_q <= link_i.src_addr;
    dst_addr_q <= link_i.dst_addr;
    src_hit_q  <= link_i.src_hit | hit_src;
    dst_hit_q  <= link_i.dst_hit | hit_dst;
  end

  assign link_o = '{valid: valid_q, src_addr: src_addr_q, dst_addr: dst_addr_q,
                    src_hit: src_hit_q, dst_hit: dst_hit_q};

endmodule

/* rtl/fsc_mod.sv */
module fsc_mod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              dividend_i,
  input  logic [fsc_pkg::FqcW-1:0] divisor_i,
  output logic                     done_o,
  output logic [fsc_pkg::FqcW-1:0] rem_o
);
  import fsc_pkg::*;

  logic            busy_q, done_q;
  logic [4:0]      cnt_q;
  logic [31:0]     dvd_q;
  logic [FqcW-1:0] div_q, rem_q, rem_d;
  logic [FqcW:0]   trial;

  // one quotient bit a cycle, msb first
  assign trial = {rem_q, dvd_q[31]};
  always_comb begin
    if (trial >= {1'b0, div_q}) begin
      rem_d = FqcW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[FqcW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/frame_subnet_classifier.sv */
// frame bytes and rule writes are taken only in the idle state
// end of frame: verdict waits for both the rule cell chain and the bit-serial modulo unit
// to finish and for the output register to be free; no input taken meanwhile
// next frame starts once the verdict is in the output register
// rst_ni clears config, frame state and handshakes; rule entries hold no reset
module frame_subnet_classifier #(
  parameter int unsigned RULE_DEPTH  = 32,
  parameter int unsigned QUEUE_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_byte, receive_queue, rule_table, rule_index, rule_network, rule_mask
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // verdict, target_queue, reason
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import fsc_pkg::*;

  state_e state_q, state_d;

  logic [CntW-1:0]  src_nrules_q, dst_nrules_q;
  logic [15:0]      flow_et_q;
  logic [FqcW-1:0]  fqc_q;
  logic [63:0]      sock_q;

  logic [5:0]       pos_q;
  logic             vlan_q, vlan_d;
  logic [15:0]      et_q, et_d;
  logic [3:0]       hlw_q, hlw_d;
  logic [7:0]       proto_q, proto_d;
  logic [31:0]      src_q, src_d, dst_q, dst_d, flow_q, flow_d;
  logic [LenW-1:0]  len_q;
  logic [QueueW-1:0] rq_q;

  logic             mod_done_q, chain_done_q;
  logic             out_valid_q;
  logic [9:0]       out_q;

  logic             accept, frame_acc, rule_acc, start, emit, ready;
  logic [7:0]       b;
  logic [5:0]       nh6, rel;
  logic [LenW-1:0]  nh;
  logic             mod_done;
  logic [FqcW-1:0]  mod_rem, flow_q_sel;
  logic             src_ok, dst_ok;
  logic [2:0]       reason;
  logic [QueueW-1:0] tq;
  rule_wr_t         wr;
  link_t            chain [RULE_DEPTH+1];

  assign b         = s_axis_tdata[7:0];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign frame_acc = accept && !s_axis_tuser;
  assign rule_acc  = accept && s_axis_tuser;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_nrules_q <= '0;
      dst_nrules_q <= '0;
      flow_et_q    <= '0;
      fqc_q        <= '0;
      sock_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSrcCount: src_nrules_q <= cfg_data_i[CntW-1:0];
        CfgDstCount: dst_nrules_q <= cfg_data_i[CntW-1:0];
        CfgFlowEt:   flow_et_q    <= cfg_data_i[15:0];
        CfgFqc:      fqc_q        <= cfg_data_i[FqcW-1:0];
        CfgSockMask: sock_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // header capture for the byte at pos_q
  always_comb begin
    et_d   = et_q;
    vlan_d = vlan_q;
    if (pos_q == 6'd12) begin
      et_d = {b, 8'h00};
    end else if (pos_q == 6'd13) begin
      et_d   = {et_q[15:8], b};
      vlan_d = ({et_q[15:8], b} == EthVlan);
    end else if (vlan_q && pos_q == 6'd16) begin
      et_d = {b, 8'h00};
    end else if (vlan_q && pos_q == 6'd17) begin
      et_d = {et_q[15:8], b};
    end
    nh6     = vlan_d ? 6'd18 : 6'd14;
    rel     = pos_q - nh6;
    hlw_d   = hlw_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    flow_d  = flow_q;
    if (pos_q >= nh6) begin
      if (rel == 6'd0) hlw_d = b[3:0];
      if (rel < 6'd4) flow_d = {flow_q[23:0], b};
      if (rel == 6'd6 && et_d == EthIpv6) proto_d = b;
      if (rel == 6'd9 && et_d != EthIpv6) proto_d = b;
      if (rel >= 6'd12 && rel < 6'd16) src_d = {src_q[23:0], b};
      if (rel >= 6'd16 && rel < 6'd20) dst_d = {dst_q[23:0], b};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      vlan_q  <= 1'b0;
      et_q    <= '0;
      hlw_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      flow_q  <= '0;
    end else if (emit) begin
      pos_q   <= '0;
      vlan_q  <= 1'b0;
      et_q    <= '0;
      hlw_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      flow_q  <= '0;
    end else if (frame_acc) begin
      if (pos_q != 6'd63) pos_q <= pos_q + 6'd1;
      vlan_q  <= vlan_d;
      et_q    <= et_d;
      hlw_q   <= hlw_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      flow_q  <= flow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_acc && s_axis_tlast) begin
      len_q <= {1'b0, pos_q} + LenW'(1);
      rq_q  <= s_axis_tdata[13:8];
    end
  end

  assign wr = '{en: rule_acc, table_sel: s_axis_tdata[14], index: s_axis_tdata[19:15],
                network: s_axis_tdata[51:20], mask: s_axis_tdata[83:52]};

  // an empty table matches anything, so the token starts out hit
  assign chain[0] = '{valid: start, src_addr: src_q, dst_addr: dst_q,
                      src_hit: (src_nrules_q == '0), dst_hit: (dst_nrules_q == '0)};

  for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
    fsc_cell #(.Idx(i)) u_cell (
      .clk_i,
      .rst_ni,
      .wr_i         (wr),
      .src_nrules_i (src_nrules_q),
      .dst_nrules_i (dst_nrules_q),
      .link_i       (chain[i]),
      .link_o       (chain[i+1])
    );
  end

  fsc_mod u_mod (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .dividend_i (flow_q),
    .divisor_i  (fqc_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign src_ok = chain[RULE_DEPTH].src_hit;
  assign dst_ok = chain[RULE_DEPTH].dst_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_done_q   <= 1'b0;
      chain_done_q <= 1'b0;
    end else if (start) begin
      mod_done_q   <= 1'b0;
      chain_done_q <= 1'b0;
    end else begin
      if (mod_done) mod_done_q <= 1'b1;
      if (chain[RULE_DEPTH].valid) chain_done_q <= 1'b1;
    end
  end

  // chain hit flags keep the last token's result while addresses and rules stay unchanged
  always_comb begin
    nh         = vlan_q ? LenW'(18) : LenW'(14);
    flow_q_sel = (fqc_q == '0) ? {1'b0, rq_q} : mod_rem;
    reason     = RsnMalformed;
    tq         = '0;
    if (len_q < nh) begin
      reason = RsnMalformed;
    end else if (et_q == EthArp) begin
      reason = RsnArp;
    end else if (et_q == EthIpv6) begin
      if (len_q < nh + LenW'(40)) reason = RsnMalformed;
      else reason = (proto_q == ProtoIcmpv6) ? RsnIcmp : RsnMalformed;
    end else if (flow_et_q != '0 && et_q == flow_et_q) begin
      if (len_q >= nh + LenW'(4) && 32'(flow_q_sel) < QUEUE_COUNT && flow_q_sel < 7'd64
          && sock_q[flow_q_sel[5:0]]) begin
        reason = RsnRedirect;
        tq     = flow_q_sel[5:0];
      end else begin
        reason = RsnNoSocket;
      end
    end else if (et_q != EthIpv4) begin
      reason = RsnMalformed;
    end else if (len_q < nh + LenW'(20) || hlw_q < 4'd5) begin
      reason = RsnMalformed;
    end else if (proto_q == ProtoIcmp) begin
      reason = RsnIcmp;
    end else if (!(src_ok && dst_ok)) begin
      reason = RsnFiltered;
    end else if (!(32'(rq_q) < QUEUE_COUNT && sock_q[rq_q])) begin
      reason = RsnNoSocket;
    end else begin
      reason = RsnRedirect;
      tq     = rq_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (frame_acc && s_axis_tlast) state_d = StStart;
      StStart: state_d = StRun;
      StRun:   if (mod_done_q && chain_done_q && (!out_valid_q || m_axis_tready))
                 state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ready = 1'b0;
    start = 1'b0;
    emit  = 1'b0;
    unique case (state_q)
      StIdle:  ready = 1'b1;
      StStart: start = 1'b1;
      StRun:   emit  = mod_done_q && chain_done_q && (!out_valid_q || m_axis_tready);
      default: ;
    endcase
  end

  assign s_axis_tready = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= {reason, tq, (reason == RsnRedirect)};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule

/* bench/fsc_checker.sv */
module fsc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [87:0] s_data_i,
  input  logic        s_last_i,
  input  logic        s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [15:0] m_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import fsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RuleDepth = 32;
  localparam int QueueCount = 64;

  // packed from the top bit down: reason, queue, verdict
  typedef struct packed {
    logic [2:0] reason;
    logic [5:0] queue;
    logic       verdict;
  } verdict_t;

  verdict_t verdicts_due[$];

  // configuration copy
  logic [5:0]  src_nrules;
  logic [5:0]  dst_nrules;
  logic [15:0] flow_et;
  logic [6:0]  flow_qcount;
  logic [63:0] sock_mask;

  // frame parse state
  logic [5:0]  pos;
  logic        vlan;
  logic [15:0] eth_type;
  logic [3:0]  ihl;
  logic [7:0]  proto;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [31:0] flow_id;

  logic [31:0] src_net [RuleDepth];
  logic [31:0] src_msk [RuleDepth];
  logic [31:0] dst_net [RuleDepth];
  logic [31:0] dst_msk [RuleDepth];

  int fails;

  assign fail_count_o = fails;
  assign pending_o = verdicts_due.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  function automatic logic src_match(input logic [31:0] a);
    if (src_nrules == 0) return 1'b1;
    for (int i = 0; i < src_nrules && i < RuleDepth; i++)
      if ((a & src_msk[i]) == (src_net[i] & src_msk[i])) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic dst_match(input logic [31:0] a);
    if (dst_nrules == 0) return 1'b1;
    for (int i = 0; i < dst_nrules && i < RuleDepth; i++)
      if ((a & dst_msk[i]) == (dst_net[i] & dst_msk[i])) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic socket_at(input int q);
    return q < QueueCount && sock_mask[q[5:0]];
  endfunction

  function automatic verdict_t classify(input int len, input logic [5:0] rq);
    verdict_t v;
    int nh;
    int q;
    v = '0;
    nh = vlan ? 18 : 14;
    if (len < nh) v.reason = RsnMalformed;
    else if (eth_type == EthArp) v.reason = RsnArp;
    else if (eth_type == EthIpv6) begin
      if (len < nh + 40) v.reason = RsnMalformed;
      else v.reason = (proto == ProtoIcmpv6) ? RsnIcmp : RsnMalformed;
    end else if (flow_et != 0 && eth_type == flow_et) begin
      v.reason = RsnNoSocket;
      if (len >= nh + 4) begin
        q = (flow_qcount != 0) ? int'(flow_id % {25'd0, flow_qcount}) : int'(rq);
        if (socket_at(q)) begin
          v.reason = RsnRedirect;
          v.queue = q[5:0];
        end
      end
    end else if (eth_type != EthIpv4 || len < nh + 20 || ihl < 5) v.reason = RsnMalformed;
    else if (proto == ProtoIcmp) v.reason = RsnIcmp;
    else if (!src_match(src_addr) || !dst_match(dst_addr)) v.reason = RsnFiltered;
    else if (!socket_at(int'(rq))) v.reason = RsnNoSocket;
    else begin
      v.reason = RsnRedirect;
      v.queue = rq;
    end
    v.verdict = (v.reason == RsnRedirect);
    return v;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic eof, input logic [5:0] rq);
    int p;
    int nh;
    p = pos;
    if (p == 12) eth_type = {b, 8'h00};
    else if (p == 13) begin
      eth_type[7:0] = b;
      vlan = (eth_type == EthVlan);
    end else if (vlan && p == 16) eth_type = {b, 8'h00};
    else if (vlan && p == 17) eth_type[7:0] = b;
    nh = vlan ? 18 : 14;
    if (p >= nh) begin
      p = p - nh;
      if (p == 0) ihl = b[3:0];
      if (p < 4) flow_id = {flow_id[23:0], b};
      if (p == 6 && eth_type == EthIpv6) proto = b;
      if (p == 9 && eth_type != EthIpv6) proto = b;
      if (p >= 12 && p < 16) src_addr = {src_addr[23:0], b};
      if (p >= 16 && p < 20) dst_addr = {dst_addr[23:0], b};
    end
    if (eof) begin
      verdicts_due.push_back(classify(int'(pos) + 1, rq));
      pos = '0;
      vlan = 1'b0;
      eth_type = '0;
      ihl = '0;
      proto = '0;
      src_addr = '0;
      dst_addr = '0;
      flow_id = '0;
    end else if (pos != 6'd63) begin
      pos = pos + 6'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got;
    verdict_t want;
    if (!rst_ni) begin
      src_nrules = '0;
      dst_nrules = '0;
      flow_et = '0;
      flow_qcount = '0;
      sock_mask = '0;
      pos = '0;
      vlan = 1'b0;
      eth_type = '0;
      ihl = '0;
      proto = '0;
      src_addr = '0;
      dst_addr = '0;
      flow_id = '0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = m_data_i[9:0];
        if (verdicts_due.size() == 0) report("verdict with none expected");
        else begin
          want = verdicts_due.pop_front();
          if (got.verdict !== want.verdict)
            report($sformatf("verdict %0d, expected %0d", got.verdict, want.verdict));
          if (got.queue !== want.queue)
            report($sformatf("queue %0d, expected %0d", got.queue, want.queue));
          if (got.reason !== want.reason)
            report($sformatf("reason %0d, expected %0d", got.reason, want.reason));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgSrcCount: src_nrules = cfg_data_i[5:0];
          CfgDstCount: dst_nrules = cfg_data_i[5:0];
          CfgFlowEt:   flow_et = cfg_data_i[15:0];
          CfgFqc:      flow_qcount = cfg_data_i[6:0];
          CfgSockMask: sock_mask = cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        if (s_user_i) begin
          // rule write: table, index, network, mask
          if (s_data_i[14]) begin
            dst_net[s_data_i[19:15]] = s_data_i[51:20];
            dst_msk[s_data_i[19:15]] = s_data_i[83:52];
          end else begin
            src_net[s_data_i[19:15]] = s_data_i[51:20];
            src_msk[s_data_i[19:15]] = s_data_i[83:52];
          end
        end else begin
          take_byte(s_data_i[7:0], s_last_i, s_data_i[13:8]);
        end
      end
    end
  end

endmodule

/* bench/tb.sv */
module tb;
  import fsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int Settle = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_rx = 1'b0;
  int items_sent = 0;
  int frames_sent = 0;

  logic [15:0] cur_flow_et;
  logic [31:0] src_net [32];
  logic [31:0] src_msk [32];
  logic [31:0] dst_net [32];
  logic [31:0] dst_msk [32];
  logic [7:0]  frame_bytes[$];

  frame_subnet_classifier u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i,
    .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  fsc_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_last_i(s_axis_tlast), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i)
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);

  task automatic push_request(input logic op, input logic [87:0] data, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  function automatic logic [31:0] prefix_mask();
    int n;
    n = $urandom_range(32);
    if ($urandom_range(7) == 0) return $urandom;
    return (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - n));
  endfunction

  task automatic write_rule(input logic tbl, input logic [4:0] idx);
    logic [31:0] net;
    logic [31:0] msk;
    logic [87:0] d;
    net = $urandom;
    msk = prefix_mask();
    if (tbl) begin
      dst_net[idx] = net;
      dst_msk[idx] = msk;
    end else begin
      src_net[idx] = net;
      src_msk[idx] = msk;
    end
    d = {4'h0, msk, net, idx, tbl, 6'($urandom), 8'($urandom)};
    push_request(1'b1, d, 1'($urandom));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    // let the checker take the last request before looking at its queue
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic configure(input logic [5:0] sc, input logic [5:0] dc, input logic [15:0] fet,
                           input logic [6:0] fqc, input logic [63:0] sock);
    write_reg(CfgSrcCount, 64'(sc));
    write_reg(CfgDstCount, 64'(dc));
    write_reg(CfgFlowEt, 64'(fet));
    write_reg(CfgFqc, 64'(fqc));
    write_reg(CfgSockMask, sock);
    cur_flow_et = fet;
  endtask

  function automatic logic [31:0] pick_addr(input logic tbl);
    int k;
    k = $urandom_range(31);
    if ($urandom_range(9) < 3) return $urandom;
    if (tbl) return (dst_net[k] & dst_msk[k]) | ($urandom & ~dst_msk[k]);
    return (src_net[k] & src_msk[k]) | ($urandom & ~src_msk[k]);
  endfunction

  // fill frame_bytes; cut > 0 truncates the frame to at most that length (kind 9 picks its own cut)
  task automatic make_frame(input int kind, input logic vlan, input int cut);
    logic [15:0] et;
    logic [31:0] a;
    int extra;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    if (vlan) begin
      frame_bytes.push_back(8'h81);
      frame_bytes.push_back(8'h00);
      repeat (2) frame_bytes.push_back(8'($urandom));
    end
    case (kind)
      5: et = EthArp;
      6: et = EthIpv6;
      7: et = (cur_flow_et != 0) ? cur_flow_et : 16'h88B5;
      8: et = 16'($urandom);
      default: et = EthIpv4;
    endcase
    frame_bytes.push_back(et[15:8]);
    frame_bytes.push_back(et[7:0]);
    extra = ($urandom_range(5) == 0) ? $urandom_range(40) : $urandom_range(3);
    if (kind <= 4) begin
      frame_bytes.push_back({4'h4, ($urandom_range(5) == 0) ? 4'($urandom) : 4'd5});
      repeat (8) frame_bytes.push_back(8'($urandom));
      case ($urandom_range(5))
        0: frame_bytes.push_back(ProtoIcmp);
        1: frame_bytes.push_back(8'($urandom));
        default: frame_bytes.push_back($urandom_range(1) ? 8'd6 : 8'd17);
      endcase
      repeat (2) frame_bytes.push_back(8'($urandom));
      a = pick_addr(1'b0);
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(a[8*i +: 8]);
      a = pick_addr(1'b1);
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(a[8*i +: 8]);
    end else if (kind == 6) begin
      repeat (6) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back($urandom_range(2) ? ProtoIcmpv6 : 8'($urandom));
      repeat (33) frame_bytes.push_back(8'($urandom));
    end else if (kind == 7) begin
      extra = $urandom_range(8);
    end else if (kind == 9) begin
      cut = $urandom_range(1, 20);
    end
    repeat (extra) frame_bytes.push_back(8'($urandom));
    while (cut > 0 && frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endtask

  task automatic send_frame();
    logic [5:0] rq;
    rq = 6'($urandom);
    foreach (frame_bytes[i]) begin
      if ($urandom_range(39) == 0) write_rule(1'($urandom), 5'($urandom));
      push_request(1'b0, {2'h0, 64'({$urandom, $urandom}), 8'($urandom), rq, frame_bytes[i]},
                   i == frame_bytes.size() - 1);
    end
    frames_sent++;
  endtask

  task automatic random_phase(input int quota);
    int start_items;
    int start_frames;
    int cut;
    start_items = items_sent;
    start_frames = frames_sent;
    while (items_sent - start_items < quota || frames_sent - start_frames < 3) begin
      cut = ($urandom_range(7) == 0) ? $urandom_range(1, 50) : 0;
      make_frame($urandom_range(9), $urandom_range(3) == 0, cut);
      send_frame();
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    configure(6'd0, 6'd0, 16'h0000, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 32; i++) begin
      write_rule(1'b0, 5'(i));
      write_rule(1'b1, 5'(i));
    end

    // directed: every frame kind with and without a tag, then cut frames and a one-byte frame
    for (int k = 0; k <= 9; k++) begin
      make_frame(k, 1'b0, 0);
      send_frame();
      make_frame(k, 1'b1, 0);
      send_frame();
    end
    make_frame(0, 1'b1, 16);
    send_frame();
    make_frame(0, 1'b0, 13);
    send_frame();
    frame_bytes = {8'hFF};
    send_frame();
    drain();
    configure(6'd32, 6'd32, 16'hFFFF, 7'd64, {$urandom, $urandom});
    make_frame(7, 1'b0, 17);
    send_frame();
    make_frame(7, 1'b0, 0);
    send_frame();
    drain();

    random_phase(110);

    send_idle_pct = 81;
    configure(6'd63, 6'd5, 16'h0800, 7'd127, 64'h0);
    random_phase(110);

    send_idle_pct = 0;
    recv_stall_pct = 81;
    configure(6'd3, 6'd63, 16'h88B5, 7'd1, {$urandom, $urandom});
    random_phase(110);

    send_idle_pct = 17;
    recv_stall_pct = 17;
    configure(6'($urandom_range(32)), 6'($urandom_range(32)), 16'h88B5,
              7'($urandom_range(64)), {$urandom, $urandom});
    random_phase(110);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    random_phase(110);

    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // receiver holds off for a long stretch while frames keep coming
  initial begin
    wait (hold_req);
    hold_rx <= 1'b1;
    repeat (600) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

endmodule
